// ===== rtl/sparse_table_engine_defines.svh =====
// ---------------------------------------------------------------------------
// Sparse table engine assertion macros
// Shared checks for the RTL; each expands to one labeled concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef SPARSE_TABLE_ENGINE_DEFINES_SVH
`define SPARSE_TABLE_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define STE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a trigger is followed by a property on the next clock edge.
`define STE_ASSERT_NEXT(name, trig, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/ste_pkg.sv =====
// ---------------------------------------------------------------------------
// Sparse table engine package
// Shared constants, operation codes and the cell command word.
// ---------------------------------------------------------------------------
package ste_pkg;

	localparam int DEF_SLOTS      = 64;
	localparam int DEF_ENTRY_BITS = 32;

	localparam int SLOT_W       = 6;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 7;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 40;

	typedef enum logic [1:0] {
		OP_GET    = 2'd0,
		OP_UPDATE = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	// Command broadcast to every cell in the commit cycle.
	typedef struct packed {
		logic wr;   // overwrite the entry at the position in place
		logic ins;  // insert: mark slot, shift entries up
		logic rem;  // remove: clear slot, shift entries down
	} cell_cmd_t;

endpackage

// ===== rtl/ste_slot_cell.sv =====
// ---------------------------------------------------------------------------
// Sparse table slot cell
// Holds one presence bit and the count of present slots below this slot.
// ---------------------------------------------------------------------------
module ste_slot_cell #(
	parameter int IDX_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               look_en,
	input  logic [IDX_W-1:0]   look_slot,
	input  ste_pkg::cell_cmd_t cmd,
	input  logic [IDX_W-1:0]   cmd_slot,
	output logic               present,
	output logic               hit,
	output logic [IDX_W-1:0]   hit_rank
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic             present_q;
	logic [IDX_W-1:0] rank_q;
	logic             look_here;
	logic             cmd_here;
	logic             cmd_above;

	assign look_here = look_en && (look_slot == MY_IDX);
	assign cmd_here  = (cmd_slot == MY_IDX);
	assign cmd_above = (MY_IDX > cmd_slot);

	assign present  = present_q;
	assign hit      = look_here && present_q;
	assign hit_rank = look_here ? rank_q : '0;

	// Track presence and rank; slots above the changed one shift their rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			rank_q    <= '0;
		end else if (cmd.ins) begin
			if (cmd_here) begin
				present_q <= 1'b1;
			end
			if (cmd_above) begin
				rank_q <= rank_q + 1'b1;
			end
		end else if (cmd.rem) begin
			if (cmd_here) begin
				present_q <= 1'b0;
			end
			if (cmd_above) begin
				rank_q <= rank_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ste_entry_cell.sv =====
// ---------------------------------------------------------------------------
// Sparse table entry cell
// Holds one packed entry; shifts with its neighbors on insert and remove.
// ---------------------------------------------------------------------------
module ste_entry_cell #(
	parameter int IDX_W    = 6,
	parameter int EW       = 32,
	parameter int CELL_IDX = 0
) (
	input  logic               clk,
	input  ste_pkg::cell_cmd_t cmd,
	input  logic [IDX_W-1:0]   pos,
	input  logic [EW-1:0]      wr_data,
	input  logic [EW-1:0]      left,
	input  logic [EW-1:0]      right,
	output logic [EW-1:0]      entry,
	output logic [EW-1:0]      sel_data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [EW-1:0] entry_q;
	logic          at_pos;
	logic          above_pos;

	assign at_pos    = (pos == MY_IDX);
	assign above_pos = (MY_IDX > pos);
	assign entry     = entry_q;
	assign sel_data  = at_pos ? entry_q : '0;

	always_ff @(posedge clk) begin
		if ((cmd.wr || cmd.ins) && at_pos) begin
			entry_q <= wr_data;
		end else if (cmd.ins && above_pos) begin
			entry_q <= left;
		end else if (cmd.rem && (at_pos || above_pos)) begin
			entry_q <= right;
		end
	end

endmodule

// ===== rtl/sparse_table_engine.sv =====
// ---------------------------------------------------------------------------
// Sparse table engine: a word passes the lookup, commit and output registers.
// One operation at a time: the rank lookup is followed by the commit in which
// the entry cells shift, and a new word enters no sooner than the previous commits.
// Reset (arst_n low) clears presence bits, ranks, count and all valids.
// ---------------------------------------------------------------------------
`include "sparse_table_engine_defines.svh"

module sparse_table_engine #(
	parameter int SLOTS      = ste_pkg::DEF_SLOTS,
	parameter int ENTRY_BITS = ste_pkg::DEF_ENTRY_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// operation [1:0], slot_index [7:2], entry_data [39:8]
	input  logic [ste_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// found [0], read_data [32:1], stored_count [39:33]
	output logic [ste_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Input word fields.
	ste_pkg::op_t                      in_op;
	logic [ste_pkg::SLOT_W-1:0]        in_slot;
	logic [ste_pkg::DATA_W-1:0]        in_data;

	assign in_op   = ste_pkg::op_t'(s_tdata[1:0]);
	assign in_slot = s_tdata[7:2];
	assign in_data = s_tdata[39:8];

	// Stage 1: lookup. The slot cell addressed reports presence and rank.
	logic                  valid_s1;
	ste_pkg::op_t          op_s1;
	logic [IDX_W-1:0]      slot_s1;
	logic                  ok_s1;
	logic [ENTRY_BITS-1:0] data_s1;

	// Stage 2: commit. Cells shift, output word is formed.
	logic                  valid_s2;
	ste_pkg::op_t          op_s2;
	logic [IDX_W-1:0]      slot_s2;
	logic                  ok_s2;
	logic [ENTRY_BITS-1:0] data_s2;
	logic                  found_s2;
	logic [IDX_W-1:0]      pos_s2;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;

	// Output register.
	logic                        out_valid_q;
	logic                        out_found_q;
	logic [ste_pkg::DATA_W-1:0]  out_data_q;
	logic [ste_pkg::COUNT_W-1:0] out_count_q;

	logic                  accept;
	logic                  commit;
	ste_pkg::cell_cmd_t    cmd;

	// Cell row wiring.
	logic [SLOTS-1:0]      present_w;
	logic [SLOTS-1:0]      hit_w;
	logic [IDX_W-1:0]      hit_rank_w [SLOTS];
	logic [ENTRY_BITS-1:0] entry_w    [SLOTS];
	logic [ENTRY_BITS-1:0] sel_w      [SLOTS];

	logic                  found_lk;
	logic [IDX_W-1:0]      pos_lk;
	logic [ENTRY_BITS-1:0] rd_sel;
	logic [ste_pkg::DATA_W-1:0] rd_word;

	// Commit whenever the output register is free or being drained.
	assign commit = valid_s2 && (!out_valid_q || m_tready);

	// One operation in flight: a new word may enter as the previous commits,
	// so the lookup sees the cells already updated.
	assign s_tready = !valid_s1 && (!valid_s2 || commit);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1 || (valid_s2 && !commit);
		end
	end

	// Capture the word; slots past the table are marked and later ignored.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= in_op;
			slot_s1 <= IDX_W'(in_slot);
			ok_s1   <= (int'(in_slot) < SLOTS);
			data_s1 <= ENTRY_BITS'(in_data);
		end
	end

	// Gather the lookup and the addressed entry from the row (one hot).
	always_comb begin
		found_lk = 1'b0;
		pos_lk   = '0;
		rd_sel   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			found_lk = found_lk | hit_w[i];
			pos_lk   = pos_lk | hit_rank_w[i];
			rd_sel   = rd_sel | sel_w[i];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			op_s2    <= op_s1;
			slot_s2  <= slot_s1;
			ok_s2    <= ok_s1;
			data_s2  <= data_s1;
			found_s2 <= found_lk;
			pos_s2   <= pos_lk;
		end
	end

	// Decode the commit into a cell command; undefined codes change nothing.
	always_comb begin
		cmd = '0;
		if (commit && ok_s2) begin
			case (op_s2)
				ste_pkg::OP_UPDATE: begin
					cmd.wr  = found_s2;
					cmd.ins = !found_s2 && (count_q < CNT_W'(SLOTS));
				end
				ste_pkg::OP_REMOVE: begin
					cmd.rem = found_s2 && (count_q != '0);
				end
				default: begin
					cmd = '0;
				end
			endcase
		end
	end

	always_comb begin
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + 1'b1;
		end else if (cmd.rem) begin
			count_next = count_q - 1'b1;
		end
	end

	// Read data only for a get that finds its slot.
	assign rd_word = (ok_s2 && found_s2 && (op_s2 == ste_pkg::OP_GET)) ?
		ste_pkg::DATA_W'(rd_sel) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_found_q <= found_s2;
			out_data_q  <= rd_word;
			out_count_q <= ste_pkg::COUNT_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_data_q, out_found_q};

	// Row of cells: slot cell i keeps slot i, entry cell i keeps packed entry i.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [ENTRY_BITS-1:0] left_w;
		logic [ENTRY_BITS-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = entry_w[i-1];
		end

		// The top entry holds on remove; anything above the count is unused.
		if (i == SLOTS - 1) begin : g_last
			assign right_w = entry_w[i];
		end else begin : g_right
			assign right_w = entry_w[i+1];
		end

		ste_slot_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_slot (
			.clk       (clk),
			.arst_n    (arst_n),
			.look_en   (valid_s1 && ok_s1),
			.look_slot (slot_s1),
			.cmd       (cmd),
			.cmd_slot  (slot_s2),
			.present   (present_w[i]),
			.hit       (hit_w[i]),
			.hit_rank  (hit_rank_w[i])
		);

		ste_entry_cell #(
			.IDX_W    (IDX_W),
			.EW       (ENTRY_BITS),
			.CELL_IDX (i)
		) u_entry (
			.clk      (clk),
			.cmd      (cmd),
			.pos      (pos_s2),
			.wr_data  (data_s2),
			.left     (left_w),
			.right    (right_w),
			.entry    (entry_w[i]),
			.sel_data (sel_w[i])
		);
	end

	`STE_ASSERT(a_single_flight, !(valid_s1 && valid_s2), "two operations in flight")
	`STE_ASSERT(a_count_bound, count_q <= CNT_W'(SLOTS), "entry count above table size")
	`STE_ASSERT(a_count_matches_map, $countones(present_w) == int'(count_q), "count differs from map")
	`STE_ASSERT_NEXT(a_commit_out, commit, m_tvalid, "commit did not load output")
	`STE_ASSERT_NEXT(a_ins_count, cmd.ins, count_q == CNT_W'($past(count_q) + 1'b1), "insert count")

endmodule
